// ===== sv/ptwc_pkg.sv =====
`timescale 1ns / 1ps

package ptwc_pkg;

  // reset value of the managed memory size
  localparam logic [15:0] TOTAL_RESET = 16'd2000;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_COMPACT = 2'd2,
    CMD_LIST    = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_MEM = 2'd1,
    ST_FULL   = 2'd2
  } status_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS,
    S_REL_RD,
    S_REL_CHK,
    S_CMP_RD,
    S_CMP_CHK,
    S_CMP_FIN,
    S_RESULT,
    S_LIST_HEAD,
    S_LIST_RD,
    S_LIST_EMIT
  } state_t;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [15:0] id;
    logic [15:0] size;
    logic        used;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic ins_commit;
    logic rd_issue;
    logic rel_check;
    logic cmp_check;
    logic cmp_finish;
    logic emit_single;
    logic emit_head;
    logic emit_entry;
  } ptwc_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic walk_last;
    logic idx_zero;
    logic out_free;
  } ptwc_stat_t;

endpackage

// ===== sv/ptwc_controller.sv =====
`timescale 1ns / 1ps

module ptwc_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            command,
  input  ptwc_pkg::ptwc_stat_t  stat,
  output logic                  in_ready,
  output ptwc_pkg::ptwc_ctrl_t  ctrl
);

  ptwc_pkg::state_t state;
  ptwc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptwc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ptwc_pkg::S_IDLE: begin
        if (in_valid) begin
          case (command)
            ptwc_pkg::CMD_INSERT:  state_next = ptwc_pkg::S_INS;
            ptwc_pkg::CMD_RELEASE: state_next = stat.count_zero ? ptwc_pkg::S_RESULT
                                                                : ptwc_pkg::S_REL_RD;
            ptwc_pkg::CMD_COMPACT: state_next = stat.count_zero ? ptwc_pkg::S_CMP_FIN
                                                                : ptwc_pkg::S_CMP_RD;
            default:               state_next = ptwc_pkg::S_LIST_HEAD;
          endcase
        end
      end
      ptwc_pkg::S_INS:     state_next = ptwc_pkg::S_RESULT;
      ptwc_pkg::S_REL_RD:  state_next = ptwc_pkg::S_REL_CHK;
      ptwc_pkg::S_REL_CHK: state_next = stat.walk_last ? ptwc_pkg::S_RESULT
                                                       : ptwc_pkg::S_REL_RD;
      ptwc_pkg::S_CMP_RD:  state_next = ptwc_pkg::S_CMP_CHK;
      ptwc_pkg::S_CMP_CHK: state_next = stat.walk_last ? ptwc_pkg::S_CMP_FIN
                                                       : ptwc_pkg::S_CMP_RD;
      ptwc_pkg::S_CMP_FIN: state_next = ptwc_pkg::S_RESULT;
      ptwc_pkg::S_RESULT: begin
        if (stat.out_free) begin
          state_next = ptwc_pkg::S_IDLE;
        end
      end
      ptwc_pkg::S_LIST_HEAD: begin
        if (stat.out_free) begin
          state_next = stat.count_zero ? ptwc_pkg::S_IDLE : ptwc_pkg::S_LIST_RD;
        end
      end
      ptwc_pkg::S_LIST_RD: state_next = ptwc_pkg::S_LIST_EMIT;
      ptwc_pkg::S_LIST_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.idx_zero ? ptwc_pkg::S_IDLE : ptwc_pkg::S_LIST_RD;
        end
      end
      default: state_next = ptwc_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl     = '0;
    in_ready = 1'b0;
    case (state)
      ptwc_pkg::S_IDLE: begin
        in_ready     = 1'b1;
        ctrl.capture = in_valid;
      end
      ptwc_pkg::S_INS:       ctrl.ins_commit = 1'b1;
      ptwc_pkg::S_REL_RD:    ctrl.rd_issue   = 1'b1;
      ptwc_pkg::S_REL_CHK:   ctrl.rel_check  = 1'b1;
      ptwc_pkg::S_CMP_RD:    ctrl.rd_issue   = 1'b1;
      ptwc_pkg::S_CMP_CHK:   ctrl.cmp_check  = 1'b1;
      ptwc_pkg::S_CMP_FIN:   ctrl.cmp_finish = 1'b1;
      ptwc_pkg::S_RESULT:    ctrl.emit_single = stat.out_free;
      ptwc_pkg::S_LIST_HEAD: ctrl.emit_head  = stat.out_free;
      ptwc_pkg::S_LIST_RD:   ctrl.rd_issue   = 1'b1;
      ptwc_pkg::S_LIST_EMIT: ctrl.emit_entry = stat.out_free;
      default: ctrl = '0;
    endcase
  end

endmodule

// ===== sv/ptwc_datapath.sv =====
`timescale 1ns / 1ps

module ptwc_datapath #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [15:0]           cfg_wdata,
  input  logic [1:0]            command,
  input  logic [15:0]           proc_id,
  input  logic [15:0]           amount,
  input  ptwc_pkg::ptwc_ctrl_t  ctrl,
  output ptwc_pkg::ptwc_stat_t  stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [15:0]           proc_id_out,
  output logic [16:0]           start_addr,
  output logic [16:0]           end_addr,
  output logic [15:0]           size_out,
  output logic                  in_use,
  output logic                  last
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  // slots are stored oldest first, so an insert appends at the count
  ptwc_pkg::slot_t mem [MAX_ENTRIES];
  ptwc_pkg::slot_t rd_data;

  logic [CNT_W-1:0] count;
  logic [15:0]      free_space;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] wr_ptr;
  logic [15:0]      op_id;
  logic [15:0]      op_amount;
  logic [1:0]       res_status;
  logic [16:0]      prev;

  logic             fits;
  logic             ins_ok;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ptwc_pkg::slot_t  mem_wdata;
  logic [16:0]      entry_start;
  logic [16:0]      entry_end;
  logic             emit_any;

  assign fits        = free_space > op_amount;
  assign ins_ok      = fits && (count < CNT_MAX);
  assign entry_start = prev + 17'd1;
  assign entry_end   = entry_start + {1'b0, rd_data.size};
  assign emit_any    = ctrl.emit_single | ctrl.emit_head | ctrl.emit_entry;

  assign stat.count_zero = (count == '0);
  assign stat.walk_last  = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign stat.idx_zero   = (idx == '0);
  assign stat.out_free   = !out_valid || out_ready;

  // single write port shared by insert, release and compaction
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = rd_data;
    if (ctrl.ins_commit && ins_ok) begin
      mem_we         = 1'b1;
      mem_waddr      = count[IDX_W-1:0];
      mem_wdata.id   = op_id;
      mem_wdata.size = op_amount;
      mem_wdata.used = 1'b1;
    end else if (ctrl.rel_check && (rd_data.id == op_id)) begin
      mem_we         = 1'b1;
      mem_wdata.used = 1'b0;
    end else if (ctrl.cmp_check && rd_data.used) begin
      mem_we    = 1'b1;
      mem_waddr = wr_ptr[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctrl.rd_issue) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      free_space <= ptwc_pkg::TOTAL_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        count      <= '0;
        free_space <= cfg_wdata;
      end else if (ctrl.ins_commit && ins_ok) begin
        count      <= count + CNT_W'(1);
        free_space <= free_space - op_amount;
      end else if (ctrl.cmp_check && !rd_data.used) begin
        free_space <= free_space + rd_data.size;
      end else if (ctrl.cmp_finish) begin
        count <= wr_ptr;
      end
      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      op_id      <= proc_id;
      op_amount  <= amount;
      wr_ptr     <= '0;
      res_status <= ptwc_pkg::ST_OK;
      // list walks newest first, the others oldest first
      idx <= (command == ptwc_pkg::CMD_LIST) ? IDX_W'(count - CNT_W'(1)) : '0;
    end
    if (ctrl.ins_commit) begin
      if (!fits) begin
        res_status <= ptwc_pkg::ST_NO_MEM;
      end else if (!ins_ok) begin
        res_status <= ptwc_pkg::ST_FULL;
      end else begin
        res_status <= ptwc_pkg::ST_OK;
      end
    end
    if (ctrl.rel_check) begin
      idx <= idx + IDX_W'(1);
    end
    if (ctrl.cmp_check) begin
      idx <= idx + IDX_W'(1);
      if (rd_data.used) begin
        wr_ptr <= wr_ptr + CNT_W'(1);
      end
    end
    if (ctrl.emit_single) begin
      status      <= res_status;
      proc_id_out <= '0;
      start_addr  <= '0;
      end_addr    <= '0;
      size_out    <= '0;
      in_use      <= 1'b0;
      last        <= 1'b1;
    end
    if (ctrl.emit_head) begin
      prev        <= {1'b0, free_space};
      status      <= ptwc_pkg::ST_OK;
      proc_id_out <= '0;
      start_addr  <= 17'd1;
      end_addr    <= {1'b0, free_space};
      size_out    <= free_space;
      in_use      <= 1'b0;
      last        <= (count == '0);
    end
    if (ctrl.emit_entry) begin
      prev        <= entry_end;
      idx         <= idx - IDX_W'(1);
      status      <= ptwc_pkg::ST_OK;
      proc_id_out <= rd_data.id;
      start_addr  <= entry_start;
      end_addr    <= entry_end;
      size_out    <= rd_data.size;
      in_use      <= rd_data.used;
      last        <= (idx == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("slot count beyond table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.ins_commit && ins_ok && !cfg_we) |=> count == $past(count) + CNT_W'(1))
    else $error("accepted insert did not add a slot");

  a_compact_shrinks: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cmp_finish && !cfg_we) |=> count <= $past(count))
    else $error("compaction grew the table");

  a_one_emit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.emit_single, ctrl.emit_head, ctrl.emit_entry}))
    else $error("more than one result loaded in a cycle");

endmodule

// ===== sv/partition_table_with_compaction_top.sv =====
`timescale 1ns / 1ps

// partition table with compaction
// input channel (in_valid/in_ready): one word carries command, proc_id and amount;
//   insert, release by id, compact, or list the table
// output channel (out_valid/out_ready): insert, release and compact give one word
//   with status and last set; list gives the free region, then one word per
//   entry newest first, with last on the final word
// configuration: cfg_we/cfg_wdata load the memory size, empty the table and
//   reload the free space; write only while the block is idle
// sequencing: insert goes through a commit state to the result word; release
//   and compact take a read state and a check state per slot, list a read
//   state and an emit state per slot, as the slot memory has a single read port
// flow: one word in flight; in_ready is high only while idle, so a new word
//   is not taken until the current command has loaded its last result word
// reset: table empty, free space 2000, no word pending; no clearing pass
// stall: a held result sits in the output register; the next word is taken
//   meanwhile, and the list walk pauses until the register frees up
module partition_table_with_compaction_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [15:0] proc_id,
  input  logic [15:0] amount,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] proc_id_out,
  output logic [16:0] start_addr,
  output logic [16:0] end_addr,
  output logic [15:0] size_out,
  output logic        in_use,
  output logic        last
);

  // command and status between the sequencer and the table datapath
  ptwc_pkg::ptwc_ctrl_t ctrl;
  ptwc_pkg::ptwc_stat_t stat;

  ptwc_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  // slot memory, free space, address walk and output register
  ptwc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .command     (command),
    .proc_id     (proc_id),
    .amount      (amount),
    .ctrl        (ctrl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .proc_id_out (proc_id_out),
    .start_addr  (start_addr),
    .end_addr    (end_addr),
    .size_out    (size_out),
    .in_use      (in_use),
    .last        (last)
  );

endmodule
